FILE: rtl/ftsc_pkg.sv
// Shared types and constants for the frustum sphere cull block.
`timescale 1ns / 1ps
`default_nettype none

package ftsc_pkg;

    // Result classes
    localparam logic [1:0] CLASS_OUTSIDE   = 2'd0;
    localparam logic [1:0] CLASS_INTERSECT = 2'd1;
    localparam logic [1:0] CLASS_INSIDE    = 2'd2;

    // Input function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    // Field widths
    localparam int unsigned COORD_W = 32;
    localparam int unsigned RAD_W   = 31;
    localparam int unsigned PROD_W  = 2 * COORD_W;
    localparam int unsigned ACC_W   = PROD_W + 2;

    // One stored plane: normal and offset, all Q16.16
    typedef struct packed {
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] d;
    } t_plane;

    localparam int unsigned PLANE_W = $bits(t_plane);

endpackage

`default_nettype wire

FILE: rtl/ftsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ftsc_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 6
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/frustum_sphere_cull.sv
// Top level: plane store and sequenced sphere-against-frustum classifier.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | func, plane_index, normal_x/y/z,
//          |           |                           | plane_offset, center_x/y/z, radius
//  out     | output    | o_out_valid / i_out_stall | cull_class
//
//  A load writes the plane store and leaves the input open. A test holds off the next
//  transfer until it is done: the one 32x32 multiplier forms three products per plane,
//  after the plane memory read in S_FETCH and before the final add and compare in S_ADD.
//  A sphere found outside a plane ends the test early.
//  Reset is synchronous, active low, and clears the sequencer and the output valid.
//  A stalled result sits in the output register; a new item is taken meanwhile, and
//  a finished test waits in its last state until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module frustum_sphere_cull #(
    parameter int unsigned NUM_PLANES = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_func,
    input  wire logic [2:0]  i_plane_index,
    input  wire logic [31:0] i_normal_x,
    input  wire logic [31:0] i_normal_y,
    input  wire logic [31:0] i_normal_z,
    input  wire logic [31:0] i_plane_offset,
    input  wire logic [31:0] i_center_x,
    input  wire logic [31:0] i_center_y,
    input  wire logic [31:0] i_center_z,
    input  wire logic [30:0] i_radius,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_cull_class
);

    localparam int unsigned AW      = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int unsigned COORD_W = ftsc_pkg::COORD_W;
    localparam int unsigned RAD_W   = ftsc_pkg::RAD_W;
    localparam int unsigned PROD_W  = ftsc_pkg::PROD_W;
    localparam int unsigned ACC_W   = ftsc_pkg::ACC_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Product component codes
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    logic [2:0]      r_state, n_state;
    logic [AW-1:0]   r_plane, n_plane;
    logic [1:0]      r_comp,  n_comp;
    logic [1:0]      r_cls,   n_cls;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_cull_class, n_cull_class;

    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic        [RAD_W-1:0]   r_rad;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc;

    logic                      w_in_xfer;
    logic                      w_load_we;
    logic                      w_out_free;
    logic [ftsc_pkg::PLANE_W-1:0] w_wdata;
    logic [ftsc_pkg::PLANE_W-1:0] w_rdata;
    ftsc_pkg::t_plane          w_plane;
    logic signed [COORD_W-1:0] w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_mul;
    logic signed [ACC_W-1:0]   w_prod_ext;
    logic signed [ACC_W-1:0]   w_dist;
    logic signed [ACC_W-1:0]   w_pos_r, w_neg_r;
    logic signed [ACC_W-1:0]   w_offset;
    logic                      w_below_neg, w_below_pos;
    logic                      w_last_plane;

    // Handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Plane store: write on an in-range load
    assign w_load_we = w_in_xfer && (i_func == ftsc_pkg::FUNC_LOAD)
                       && ({2'b00, i_plane_index} < 5'(NUM_PLANES));
    assign w_wdata   = {i_normal_x, i_normal_y, i_normal_z, i_plane_offset};

    ftsc_ram #(
        .WIDTH (ftsc_pkg::PLANE_W),
        .DEPTH (NUM_PLANES)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (AW'(i_plane_index)),
        .i_wdata (w_wdata),
        .i_raddr (r_plane),
        .o_rdata (w_rdata)
    );

    assign w_plane = ftsc_pkg::t_plane'(w_rdata);

    // Select the operands for the shared multiplier
    always_comb begin
        case (r_comp)
            COMP_X: begin
                w_mul_a = w_plane.nx;
                w_mul_b = r_cx;
            end
            COMP_Y: begin
                w_mul_a = w_plane.ny;
                w_mul_b = r_cy;
            end
            COMP_Z: begin
                w_mul_a = w_plane.nz;
                w_mul_b = r_cz;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // Distance and radius bounds, all Q34.32
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_offset   = {{(ACC_W-COORD_W-16){w_plane.d[COORD_W-1]}}, w_plane.d, 16'b0};
    assign w_dist     = r_acc + w_prod_ext;
    assign w_pos_r    = {{(ACC_W-RAD_W-16){1'b0}}, r_rad, 16'b0};
    assign w_neg_r    = -w_pos_r;
    assign w_below_neg = (w_dist < w_neg_r);
    assign w_below_pos = (w_dist < w_pos_r);
    assign w_last_plane = (r_plane == AW'(NUM_PLANES - 1));

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_plane      = r_plane;
        n_comp       = r_comp;
        n_cls        = r_cls;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && i_out_stall;
        n_cull_class = r_cull_class;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_func == ftsc_pkg::FUNC_TEST)) begin
                    n_state = S_FETCH;
                    n_plane = '0;
                    n_cls   = ftsc_pkg::CLASS_INSIDE;
                end
            end
            S_FETCH: begin
                n_state = S_MUL;
                n_comp  = COMP_X;
            end
            S_MUL: begin
                // Seed with the offset, then fold in each product
                if (r_comp == COMP_X) begin
                    n_acc = w_offset;
                end else begin
                    n_acc = w_dist;
                end
                if (r_comp == COMP_Z) begin
                    n_state = S_ADD;
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            S_ADD: begin
                if (w_below_neg) begin
                    n_cls   = ftsc_pkg::CLASS_OUTSIDE;
                    n_state = S_DONE;
                end else begin
                    if (w_below_pos) begin
                        n_cls = ftsc_pkg::CLASS_INTERSECT;
                    end
                    if (w_last_plane) begin
                        n_state = S_DONE;
                    end else begin
                        n_plane = r_plane + AW'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            S_DONE: begin
                // Hold until the output register can take the result
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_cull_class = r_cls;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_plane      <= n_plane;
        r_comp       <= n_comp;
        r_cls        <= n_cls;
        r_acc        <= n_acc;
        r_prod       <= w_mul;
        r_cull_class <= n_cull_class;
        if (w_in_xfer) begin
            r_cx  <= i_center_x;
            r_cy  <= i_center_y;
            r_cz  <= i_center_z;
            r_rad <= i_radius;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cull_class = r_cull_class;

    // A test transfer starts the sequencer and blocks input on the next cycle
    a_test_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_func == ftsc_pkg::FUNC_TEST)) |=> (r_state == S_FETCH && o_in_stall))
        else $error("test transfer did not start the sequencer");

    // The plane counter stays inside the table while a test runs
    a_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_plane <= AW'(NUM_PLANES - 1)))
        else $error("plane counter out of range");

    // A new result appears only out of the final sequencer state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && i_out_stall)) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished test");

    // A result is always a defined class
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cull_class != 2'd3))
        else $error("undefined result class");

endmodule

`default_nettype wire
